FILE: src/sha256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned ROUND_COUNT = 64;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned STATE_WORDS = 8;

    // command from controller to datapath
    typedef struct packed {
        logic       load_byte;   // write data byte at fill position
        logic       pad_byte;    // write padding byte (0x80 or 0x00) at fill position
        logic       pad_first;   // padding byte is 0x80
        logic       write_len;   // write bit length into words 14 and 15
        logic       count_byte;  // advance message length
        logic       start;       // load working vars from chain state
        logic       round;       // run one round
        logic       finish;      // add working vars into chain state
        logic       reinit;      // reset chain state and length
        logic       shift_out;   // rotate chain state for digest output
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
        logic       round_done;
    } t_stat;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
        rotr = (v >> s) | (v << (32 - s));
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        case (i)
            3'd0: init_h = 32'h6a09e667;
            3'd1: init_h = 32'hbb67ae85;
            3'd2: init_h = 32'h3c6ef372;
            3'd3: init_h = 32'ha54ff53a;
            3'd4: init_h = 32'h510e527f;
            3'd5: init_h = 32'h9b05688c;
            3'd6: init_h = 32'h1f83d9ab;
            default: init_h = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [0:63];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        round_k = k[i];
    endfunction

endpackage
`default_nettype wire

FILE: src/sha256_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_datapath
// Block buffer, message schedule window, round unit and chaining state.
// ----------------------------------------------------------------------------
module sha256_datapath
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [7:0]  i_data_byte,
    output t_stat            o_stat,
    output logic [31:0]      o_digest_word
);

    logic [31:0] r_blk [0:15];
    logic [31:0] r_w   [0:15];
    logic [31:0] r_h   [0:7];
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_hh;
    logic [5:0]  r_fill;
    logic [5:0]  r_rnd;
    logic [60:0] r_len;

    logic [7:0]  byte_val;
    logic [3:0]  wsel;
    logic [4:0]  bshift;
    logic [31:0] s0, s1, w_new, t1, t2;
    logic [63:0] bits;

    assign byte_val = i_cmd.load_byte ? i_data_byte : (i_cmd.pad_first ? 8'h80 : 8'h00);
    assign wsel     = r_fill[5:2];
    assign bshift   = {~r_fill[1:0], 3'b000};
    assign bits     = {r_len, 3'b000};

    assign s0    = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1    = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_new = r_w[0] + s0 + r_w[9] + s1;
    assign t1    = r_hh + (rotr(r_e, 6) ^ rotr(r_e, 11) ^ rotr(r_e, 25))
                 + ((r_e & r_f) ^ (~r_e & r_g)) + round_k(r_rnd) + r_w[0];
    assign t2    = (rotr(r_a, 2) ^ rotr(r_a, 13) ^ rotr(r_a, 22))
                 + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));

    assign o_stat.fill       = r_fill;
    assign o_stat.round_done = (r_rnd == 6'd63);
    assign o_digest_word     = r_h[0];

    // block buffer and schedule window
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte || i_cmd.pad_byte) begin
            r_blk[wsel] <= (r_blk[wsel] & ~(32'hff << bshift))
                         | ({24'd0, byte_val} << bshift);
        end
        if (i_cmd.write_len) begin
            r_blk[14] <= bits[63:32];
            r_blk[15] <= bits[31:0];
        end
        if (i_cmd.start) begin
            for (int i = 0; i < 16; i++) r_w[i] <= r_blk[i];
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
            r_e <= r_h[4]; r_f <= r_h[5]; r_g <= r_h[6]; r_hh <= r_h[7];
        end else if (i_cmd.round) begin
            r_hh <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
            r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reinit) begin
            for (int i = 0; i < 8; i++) r_h[i] <= init_h(3'(i));
        end else if (i_cmd.finish) begin
            r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
            r_h[4] <= r_h[4] + r_e; r_h[5] <= r_h[5] + r_f;
            r_h[6] <= r_h[6] + r_g; r_h[7] <= r_h[7] + r_hh;
        end else if (i_cmd.shift_out) begin
            for (int i = 0; i < 7; i++) r_h[i] <= r_h[i+1];
            r_h[7] <= r_h[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_rnd  <= '0;
            r_len  <= '0;
        end else begin
            if (i_cmd.load_byte || i_cmd.pad_byte) r_fill <= r_fill + 6'd1;
            else if (i_cmd.write_len)              r_fill <= '0;
            if (i_cmd.start)      r_rnd <= '0;
            else if (i_cmd.round) r_rnd <= r_rnd + 6'd1;
            if (i_cmd.reinit)          r_len <= '0;
            else if (i_cmd.count_byte) r_len <= r_len + 61'd1;
        end
    end

endmodule
`default_nettype wire

FILE: src/sha256_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer: byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_byte_valid,
    input  wire logic        i_last_item,
    input  wire t_stat       i_stat,
    output t_cmd             o_cmd,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_word_index,
    output logic             o_digest_last
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD0  = 3'd1; // write 0x80
    localparam logic [2:0] ST_PADZ  = 3'd2; // zero fill
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_START = 3'd4;
    localparam logic [2:0] ST_ROUND = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_final, n_final;   // compression belongs to padding
    logic       r_last,  n_last;    // final block of padding
    logic [2:0] r_idx,   n_idx;
    logic       take;
    // 0x80 not yet written when a byte filled the block on the last item
    logic       r_pad_pending, n_pad_pending;

    assign o_stall       = (r_state != ST_IDLE);
    assign take          = i_valid && (r_state == ST_IDLE);
    assign o_valid       = (r_state == ST_OUT);
    assign o_word_index  = r_idx;
    assign o_digest_last = (r_idx == 3'd7);

    always_comb begin
        n_state = r_state;
        n_final = r_final;
        n_last  = r_last;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    o_cmd.load_byte  = i_byte_valid;
                    o_cmd.count_byte = i_byte_valid;
                    n_final = i_last_item;
                    n_last  = 1'b0;
                    if (i_byte_valid && i_stat.fill == 6'd63) n_state = ST_START;
                    else if (i_last_item)                     n_state = ST_PAD0;
                end
            end
            ST_PAD0: begin
                o_cmd.pad_byte  = 1'b1;
                o_cmd.pad_first = 1'b1;
                if (i_stat.fill == 6'd63) n_state = ST_START;
                else n_state = ST_PADZ;
            end
            ST_PADZ: begin
                // fill to 56 when room for length, else to end of block
                if (i_stat.fill == 6'd56) begin
                    n_state = ST_LEN;
                end else begin
                    o_cmd.pad_byte = 1'b1;
                    if (i_stat.fill == 6'd63) n_state = ST_START;
                end
            end
            ST_LEN: begin
                o_cmd.write_len = 1'b1;
                n_last  = 1'b1;
                n_state = ST_START;
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_stat.round_done) n_state = ST_FIN;
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_idx = '0;
                // a full block on a byte+last item: pad starts after its compression
                if (!r_final)          n_state = ST_IDLE;
                else if (r_last)       n_state = ST_OUT;
                else if (r_pad_pending) n_state = ST_PAD0;
                else                   n_state = ST_PADZ;
            end
            ST_OUT: begin
                if (!i_stall) begin
                    o_cmd.shift_out = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.reinit = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_pad_pending = r_pad_pending;
        if (take) n_pad_pending = i_last_item && i_byte_valid && i_stat.fill == 6'd63;
        else if (r_state == ST_PAD0) n_pad_pending = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_final       <= 1'b0;
            r_last        <= 1'b0;
            r_idx         <= '0;
            r_pad_pending <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_final       <= n_final;
            r_last        <= n_last;
            r_idx         <= n_idx;
            r_pad_pending <= n_pad_pending;
        end
    end

endmodule
`default_nettype wire

FILE: src/sha256_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream, digest out as eight 32-bit words.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | i_valid / o_stall  | i_data_byte, i_byte_valid, i_last_item
//  out     | o_valid / i_stall  | o_digest_word, o_word_index, o_digest_last
//
// A byte that does not fill the block leaves the sequencer idle. A byte
// completing a block runs the intake, load, 64 rounds of the single round
// unit and the final add. A last item adds the 0x80 byte, zero fill at one
// byte a cycle, the length write, one or two compressions (load, rounds,
// final add), then eight output words (held while the output stalls).
// Reset (synchronous, active low) restores the initial hash and a zero length.
// o_stall is high whenever the sequencer is busy.
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_last_item,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_digest_last
);

    t_cmd  cmd;
    t_stat stat;

    // sequence intake, padding, rounds and output
    sha256_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_byte_valid, .i_last_item,
        .i_stat(stat), .o_cmd(cmd), .o_valid, .i_stall, .o_word_index, .o_digest_last
    );

    // hold block, schedule and chaining state
    sha256_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_data_byte,
        .o_stat(stat), .o_digest_word
    );

endmodule
`default_nettype wire

FILE: src/sha256_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
module sha256_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_digest_word,
    input wire logic [2:0]  o_word_index,
    input wire logic        o_digest_last
);

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digest_last == (o_word_index == 3'd7)))
        else $error("digest_last mismatch");

    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open during output");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_digest_last) |=> (o_valid &&
            o_word_index == $past(o_word_index) + 3'd1))
        else $error("word index skipped");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_digest_word)))
        else $error("stalled word changed");

endmodule

bind sha256_stream_hasher sha256_checker u_chk (.*);
`default_nettype wire
